FILE: sv/apsp_pkg.sv
// shared types, constants and command codes for the shortest path block
package apsp_pkg;

    localparam int SLOTS        = 8;
    localparam int VERTEX_W     = 3;
    localparam int ADDR_W       = 2 * VERTEX_W;
    localparam int DEPTH        = SLOTS * SLOTS;
    localparam int STORE_W      = 16;
    localparam int DIST_W       = 19;
    localparam int VERTICES_DEF = 8;

    localparam logic [STORE_W-1:0] NO_EDGE = 16'hFFFF;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_EDGE    = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    typedef struct packed {
        logic                en;
        logic                keep_via;
        logic [ADDR_W-1:0]   addr;
        logic [STORE_W-1:0]  cost;
        logic [VERTEX_W-1:0] via;
    } mem_wr_t;

    typedef struct packed {
        logic [STORE_W-1:0]  cost;
        logic [VERTEX_W-1:0] via;
    } mem_rd_t;

endpackage

FILE: sv/apsp_cmd_if.sv
// command channel: valid, ready and the command item
interface apsp_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           command;
    logic [apsp_pkg::VERTEX_W-1:0]        vertex_a;
    logic [apsp_pkg::VERTEX_W-1:0]        vertex_b;
    logic [apsp_pkg::STORE_W-1:0]         weight;

    modport source (output valid, output command, output vertex_a, output vertex_b,
                    output weight, input ready);
    modport sink   (input valid, input command, input vertex_a, input vertex_b,
                    input weight, output ready);
endinterface

FILE: sv/apsp_entry_if.sv
// result channel: valid, ready and one matrix entry item
interface apsp_entry_if;
    logic                                 valid;
    logic                                 ready;
    logic [apsp_pkg::VERTEX_W-1:0]        row;
    logic [apsp_pkg::VERTEX_W-1:0]        col;
    logic [apsp_pkg::DIST_W-1:0]          distance;
    logic [apsp_pkg::VERTEX_W-1:0]        via;
    logic                                 last;

    modport source (output valid, output row, output col, output distance, output via,
                    output last, input ready);
    modport sink   (input valid, input row, input col, input distance, input via,
                    input last, output ready);
endinterface

FILE: sv/apsp_mem.sv
// distance and via matrix store: two registered read ports, one write port, valid bits
module apsp_mem
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  apsp_pkg::mem_wr_t             wr,
    input  logic [apsp_pkg::ADDR_W-1:0]   raddr_a,
    input  logic [apsp_pkg::ADDR_W-1:0]   raddr_b,
    output apsp_pkg::mem_rd_t             rd_a,
    output apsp_pkg::mem_rd_t             rd_b
);

    logic [apsp_pkg::STORE_W-1:0]  dist_mem [apsp_pkg::DEPTH];
    logic [apsp_pkg::VERTEX_W-1:0] via_mem  [apsp_pkg::DEPTH];
    logic [apsp_pkg::DEPTH-1:0]    valid_reg;

    logic [apsp_pkg::STORE_W-1:0]  qa_dist_reg;
    logic [apsp_pkg::STORE_W-1:0]  qb_dist_reg;
    logic [apsp_pkg::VERTEX_W-1:0] qa_via_reg;
    logic [apsp_pkg::ADDR_W-1:0]   addr_a_reg;
    logic [apsp_pkg::ADDR_W-1:0]   addr_b_reg;
    logic                          va_reg;
    logic                          vb_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            dist_mem[wr.addr] <= wr.cost;
            // a kept via entry is only rewritten while it still reads as its row
            if (!(wr.keep_via && valid_reg[wr.addr]))
            begin
                via_mem[wr.addr] <= wr.via;
            end
        end
        qa_dist_reg <= dist_mem[raddr_a];
        qa_via_reg  <= via_mem[raddr_a];
        qb_dist_reg <= dist_mem[raddr_b];
        addr_a_reg  <= raddr_a;
        addr_b_reg  <= raddr_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end
        else
        begin
            va_reg <= valid_reg[raddr_a];
            vb_reg <= valid_reg[raddr_b];
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
        end
    end

    // entries never written since a clear read as the initial matrix
    always_comb
    begin
        if (va_reg)
        begin
            rd_a.cost = qa_dist_reg;
            rd_a.via  = qa_via_reg;
        end
        else
        begin
            rd_a.cost = (addr_a_reg[apsp_pkg::ADDR_W-1:apsp_pkg::VERTEX_W] ==
                         addr_a_reg[apsp_pkg::VERTEX_W-1:0]) ? '0 : apsp_pkg::NO_EDGE;
            rd_a.via  = addr_a_reg[apsp_pkg::ADDR_W-1:apsp_pkg::VERTEX_W];
        end
        if (vb_reg)
        begin
            rd_b.cost = qb_dist_reg;
        end
        else
        begin
            rd_b.cost = (addr_b_reg[apsp_pkg::ADDR_W-1:apsp_pkg::VERTEX_W] ==
                         addr_b_reg[apsp_pkg::VERTEX_W-1:0]) ? '0 : apsp_pkg::NO_EDGE;
        end
        rd_b.via = addr_b_reg[apsp_pkg::ADDR_W-1:apsp_pkg::VERTEX_W];
    end

endmodule

FILE: sv/apsp_relax.sv
// relaxation unit: one add and one strict compare
module apsp_relax
(
    input  logic [apsp_pkg::STORE_W-1:0] d_ik,
    input  logic [apsp_pkg::STORE_W-1:0] d_kj,
    input  logic [apsp_pkg::STORE_W-1:0] d_ij,
    output logic                         take,
    output logic [apsp_pkg::STORE_W-1:0] new_dist
);

    logic [apsp_pkg::STORE_W:0] through;

    always_comb
    begin
        through  = {1'b0, d_ik} + {1'b0, d_kj};
        take     = {1'b0, d_ij} > through;
        // a winning sum is below the current entry, so it fits the store width
        new_dist = through[apsp_pkg::STORE_W-1:0];
    end

endmodule

FILE: sv/all_pairs_shortest_path.sv
// top level: command sequencer for the all pairs shortest path block
//
//  channel | dir | item                                   | accepted when
//  cmd     | in  | command, vertex_a, vertex_b, weight    | cmd.valid && cmd.ready
//  result  | out | row, col, distance, via, last          | result.valid && result.ready
//
// clear and an ignored command complete in the accept cycle; an edge writes a,b there and b,a in ST_EDGE2
// compute: relaxation through the single add/compare unit and the two-read-port matrix store
// (ST_RD_IK, ST_LD_IK per row; ST_RD_IJ, ST_CMP per entry), then ST_EMIT_RD/LD/WAIT per entry
// reset leaves the initial matrices in place through per-entry valid bits, no sweep
// cmd.ready is low while a command is in progress; a stalled result holds the sequencer
module all_pairs_shortest_path
#(
    parameter int VERTICES = apsp_pkg::VERTICES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    apsp_cmd_if.sink     cmd,
    apsp_entry_if.source result
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_EDGE2     = 4'd1;
    localparam logic [3:0] ST_RD_IK     = 4'd2;
    localparam logic [3:0] ST_LD_IK     = 4'd3;
    localparam logic [3:0] ST_RD_IJ     = 4'd4;
    localparam logic [3:0] ST_CMP       = 4'd5;
    localparam logic [3:0] ST_EMIT_RD   = 4'd6;
    localparam logic [3:0] ST_EMIT_LD   = 4'd7;
    localparam logic [3:0] ST_EMIT_WAIT = 4'd8;

    localparam int VW = apsp_pkg::VERTEX_W;
    localparam logic [VW-1:0] LAST_V  = VW'(VERTICES - 1);
    localparam logic [VW:0]   V_COUNT = (VW + 1)'(VERTICES);

    logic [3:0]                   state_reg, state_next;
    logic [VW-1:0]                i_reg, i_next;
    logic [VW-1:0]                j_reg, j_next;
    logic [VW-1:0]                k_reg, k_next;
    logic [VW-1:0]                ea_reg, ea_next;
    logic [VW-1:0]                eb_reg, eb_next;
    logic [apsp_pkg::STORE_W-1:0] weight_reg, weight_next;
    logic [apsp_pkg::STORE_W-1:0] dik_reg, dik_next;

    logic [VW-1:0]                out_row_reg, out_row_next;
    logic [VW-1:0]                out_col_reg, out_col_next;
    logic [apsp_pkg::STORE_W-1:0] out_dist_reg, out_dist_next;
    logic [VW-1:0]                out_via_reg, out_via_next;
    logic                         out_last_reg, out_last_next;

    logic                         accept;
    logic                         clear;
    logic                         take;
    logic [apsp_pkg::STORE_W-1:0] new_dist;
    logic [apsp_pkg::ADDR_W-1:0]  raddr_a;
    logic [apsp_pkg::ADDR_W-1:0]  raddr_b;
    apsp_pkg::mem_wr_t            wr;
    apsp_pkg::mem_rd_t            rd_a;
    apsp_pkg::mem_rd_t            rd_b;

    apsp_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .wr      (wr),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rd_a    (rd_a),
        .rd_b    (rd_b)
    );

    apsp_relax u_relax
    (
        .d_ik     (dik_reg),
        .d_kj     (rd_b.cost),
        .d_ij     (rd_a.cost),
        .take     (take),
        .new_dist (new_dist)
    );

    assign cmd.ready       = (state_reg == ST_IDLE);
    assign accept          = cmd.valid && cmd.ready;
    assign result.valid    = (state_reg == ST_EMIT_WAIT);
    assign result.row      = out_row_reg;
    assign result.col      = out_col_reg;
    assign result.distance = apsp_pkg::DIST_W'(out_dist_reg);
    assign result.via      = out_via_reg;
    assign result.last     = out_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        ea_next       = ea_reg;
        eb_next       = eb_reg;
        weight_next   = weight_reg;
        dik_next      = dik_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_dist_next = out_dist_reg;
        out_via_next  = out_via_reg;
        out_last_next = out_last_reg;
        clear         = 1'b0;
        raddr_a       = {i_reg, j_reg};
        raddr_b       = {k_reg, j_reg};
        wr.en         = 1'b0;
        wr.keep_via   = 1'b0;
        wr.addr       = {i_reg, j_reg};
        wr.cost       = new_dist;
        wr.via        = k_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.command)
                        apsp_pkg::CMD_CLEAR:
                        begin
                            clear = 1'b1;
                        end
                        apsp_pkg::CMD_EDGE:
                        begin
                            if (({1'b0, cmd.vertex_a} < V_COUNT) &&
                                ({1'b0, cmd.vertex_b} < V_COUNT))
                            begin
                                wr.en       = 1'b1;
                                wr.keep_via = 1'b1;
                                wr.addr     = {cmd.vertex_a, cmd.vertex_b};
                                wr.cost     = cmd.weight;
                                wr.via      = cmd.vertex_a;
                                ea_next     = cmd.vertex_a;
                                eb_next     = cmd.vertex_b;
                                weight_next = cmd.weight;
                                state_next  = ST_EDGE2;
                            end
                        end
                        apsp_pkg::CMD_COMPUTE:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            state_next = ST_RD_IK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EDGE2:
            begin
                // an edge leaves the via entry alone; a never written entry takes its row index
                wr.en       = 1'b1;
                wr.keep_via = 1'b1;
                wr.addr     = {eb_reg, ea_reg};
                wr.cost     = weight_reg;
                wr.via      = eb_reg;
                state_next  = ST_IDLE;
            end
            ST_RD_IK:
            begin
                raddr_a    = {i_reg, k_reg};
                state_next = ST_LD_IK;
            end
            ST_LD_IK:
            begin
                dik_next   = rd_a.cost;
                j_next     = '0;
                state_next = ST_RD_IJ;
            end
            ST_RD_IJ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // a write to the i,k or k,j entries never wins, so the held i,k value stays
                wr.en = take;
                wr.via = rd_a.via;
                if (take)
                begin
                    wr.via = k_reg;
                end
                if (j_reg != LAST_V)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_RD_IJ;
                end
                else if (i_reg != LAST_V)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RD_IK;
                end
                else if (k_reg != LAST_V)
                begin
                    i_next     = '0;
                    k_next     = k_reg + 1'b1;
                    state_next = ST_RD_IK;
                end
                else
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                out_row_next  = i_reg;
                out_col_next  = j_reg;
                out_dist_next = rd_a.cost;
                out_via_next  = rd_a.via;
                out_last_next = (i_reg == LAST_V) && (j_reg == LAST_V);
                state_next    = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (result.ready)
                begin
                    if (out_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (j_reg != LAST_V)
                        begin
                            j_next = j_reg + 1'b1;
                        end
                        else
                        begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ea_reg       <= ea_next;
        eb_reg       <= eb_next;
        weight_reg   <= weight_next;
        dik_reg      <= dik_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_dist_reg <= out_dist_next;
        out_via_reg  <= out_via_next;
        out_last_reg <= out_last_next;
    end

endmodule

FILE: bench/all_pairs_shortest_path_tb.sv
// testbench for the all pairs shortest path block: predicted matrix entries checked in order

typedef struct packed {
    logic [apsp_pkg::VERTEX_W-1:0] row;
    logic [apsp_pkg::VERTEX_W-1:0] col;
    logic [apsp_pkg::DIST_W-1:0]   distance;
    logic [apsp_pkg::VERTEX_W-1:0] via;
    logic                          last;
} entry_t;

class path_scoreboard;
    localparam int NV = apsp_pkg::VERTICES_DEF;

    logic [apsp_pkg::DIST_W-1:0]   dist_now [apsp_pkg::SLOTS][apsp_pkg::SLOTS];
    logic [apsp_pkg::VERTEX_W-1:0] via_now  [apsp_pkg::SLOTS][apsp_pkg::SLOTS];
    entry_t                        expected_entries [$];
    int                            errors;

    function new();
        errors = 0;
        reset_matrices();
    endfunction

    function void reset_matrices();
        for (int r = 0; r < apsp_pkg::SLOTS; r++)
        begin
            for (int c = 0; c < apsp_pkg::SLOTS; c++)
            begin
                dist_now[r][c] = (r == c) ? '0 : 19'(apsp_pkg::NO_EDGE);
                via_now[r][c]  = r[apsp_pkg::VERTEX_W-1:0];
            end
        end
    endfunction

    function void note_command(input logic [1:0] command,
                               input logic [apsp_pkg::VERTEX_W-1:0] a,
                               input logic [apsp_pkg::VERTEX_W-1:0] b,
                               input logic [apsp_pkg::STORE_W-1:0] w);
        entry_t      e;
        logic [19:0] through;
        case (command)
            apsp_pkg::CMD_CLEAR:
                reset_matrices();
            apsp_pkg::CMD_EDGE:
                if (a < NV && b < NV)
                begin
                    dist_now[a][b] = 19'(w);
                    dist_now[b][a] = 19'(w);
                end
            apsp_pkg::CMD_COMPUTE:
            begin
                for (int k = 0; k < NV; k++)
                begin
                    for (int i = 0; i < NV; i++)
                    begin
                        for (int j = 0; j < NV; j++)
                        begin
                            through = 20'(dist_now[i][k]) + 20'(dist_now[k][j]);
                            if (20'(dist_now[i][j]) > through)
                            begin
                                dist_now[i][j] = through[apsp_pkg::DIST_W-1:0];
                                via_now[i][j]  = k[apsp_pkg::VERTEX_W-1:0];
                            end
                        end
                    end
                end
                for (int i = 0; i < NV; i++)
                begin
                    for (int j = 0; j < NV; j++)
                    begin
                        e.row      = i[apsp_pkg::VERTEX_W-1:0];
                        e.col      = j[apsp_pkg::VERTEX_W-1:0];
                        e.distance = dist_now[i][j];
                        e.via      = via_now[i][j];
                        e.last     = (i == NV - 1 && j == NV - 1);
                        expected_entries.push_back(e);
                    end
                end
            end
            default:
                ;
        endcase
    endfunction

    function void check_entry(input entry_t got);
        entry_t want;
        if (expected_entries.size() == 0)
        begin
            $error("unexpected result item: row %0d col %0d distance %0d",
                   got.row, got.col, got.distance);
            errors++;
            return;
        end
        want = expected_entries.pop_front();
        if (got.row !== want.row)
        begin
            $error("row: expected %0d, actual %0d", want.row, got.row);
            errors++;
        end
        if (got.col !== want.col)
        begin
            $error("col: expected %0d, actual %0d", want.col, got.col);
            errors++;
        end
        if (got.distance !== want.distance)
        begin
            $error("distance: expected %0d, actual %0d", want.distance, got.distance);
            errors++;
        end
        if (got.via !== want.via)
        begin
            $error("via: expected %0d, actual %0d", want.via, got.via);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
        end
    endfunction
endclass

module all_pairs_shortest_path_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         COMMAND_GOAL = 400;
    localparam int         HOLD_AFTER   = 300;
    localparam int         HOLD_CYCLES  = 3000;

    logic clk = 1'b0;
    logic rst_n;

    apsp_cmd_if   cmd_bus ();
    apsp_entry_if result_bus ();

    all_pairs_shortest_path dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .result (result_bus)
    );

    path_scoreboard sb;
    int             commands_sent = 0;
    int             results_seen  = 0;
    int             cmd_burst     = 0;
    int             res_burst     = 0;

    always #6 clk = ~clk;

    function automatic int draw_gap(inout int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [15:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return apsp_pkg::NO_EDGE;
            2:       return 16'hFFFE;
            3, 4:    return 16'($urandom_range(1, 40));
            5:       return 16'($urandom_range(1, 1000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_command(input logic [1:0] command, input logic [2:0] a,
                                input logic [2:0] b, input logic [15:0] w);
        int gap;
        gap = draw_gap(cmd_burst);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.command  <= command;
        cmd_bus.vertex_a <= a;
        cmd_bus.vertex_b <= b;
        cmd_bus.weight   <= w;
        do @(posedge clk); while (!cmd_bus.ready);
        sb.note_command(command, a, b, w);
        if (command != CMD_UNUSED)
            commands_sent++;
    endtask

    task automatic send_random_edges(input int count);
        repeat (count)
            send_command(apsp_pkg::CMD_EDGE, 3'($urandom), 3'($urandom), pick_weight());
    endtask

    initial
    begin
        #60ms;
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, one long hold-off that stalls the sequencer and the command side
    initial
    begin
        int     gap;
        bit     held;
        entry_t got;
        held = 1'b0;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(res_burst);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            if (gap > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (!result_bus.valid);
            got.row      = result_bus.row;
            got.col      = result_bus.col;
            got.distance = result_bus.distance;
            got.via      = result_bus.via;
            got.last     = result_bus.last;
            sb.check_entry(got);
            results_seen++;
        end
    end

    initial
    begin
        int choice;
        sb = new();
        rst_n            <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.command  <= apsp_pkg::CMD_CLEAR;
        cmd_bus.vertex_a <= '0;
        cmd_bus.vertex_b <= '0;
        cmd_bus.weight   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // matrices straight out of reset
        send_command(apsp_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'd0);
        send_command(apsp_pkg::CMD_EDGE, 3'd0, 3'd7, 16'd0);
        send_command(apsp_pkg::CMD_EDGE, 3'd7, 3'd6, apsp_pkg::NO_EDGE);
        // self edge lands on the diagonal
        send_command(apsp_pkg::CMD_EDGE, 3'd3, 3'd3, 16'd5);
        send_command(apsp_pkg::CMD_EDGE, 3'd1, 3'd2, 16'hFFFE);
        send_command(apsp_pkg::CMD_EDGE, 3'd2, 3'd5, 16'hFFFE);
        send_command(CMD_UNUSED, 3'd5, 3'd5, 16'd1);
        send_command(apsp_pkg::CMD_COMPUTE, 3'd7, 3'd7, 16'hFFFF);
        send_command(apsp_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'd0);
        send_command(apsp_pkg::CMD_CLEAR, 3'd7, 3'd7, 16'hFFFF);
        // chain through all vertices plus a long shortcut
        for (int v = 0; v < 7; v++)
            send_command(apsp_pkg::CMD_EDGE, 3'(v), 3'(v + 1), 16'd1);
        send_command(apsp_pkg::CMD_EDGE, 3'd0, 3'd7, 16'd10);
        send_command(apsp_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'd0);
        send_command(apsp_pkg::CMD_CLEAR, 3'd0, 3'd0, 16'd0);
        send_command(apsp_pkg::CMD_COMPUTE, 3'd0, 3'd0, 16'd0);

        while (commands_sent < COMMAND_GOAL)
        begin
            choice = $urandom_range(0, 19);
            if (choice < 17)
            begin
                send_command(apsp_pkg::CMD_CLEAR, 3'($urandom), 3'($urandom), 16'($urandom));
                send_random_edges($urandom_range(0, 14));
                send_command(apsp_pkg::CMD_COMPUTE, 3'($urandom), 3'($urandom),
                             16'($urandom));
                if ($urandom_range(0, 3) == 0)
                begin
                    send_random_edges($urandom_range(0, 3));
                    send_command(apsp_pkg::CMD_COMPUTE, 3'($urandom), 3'($urandom),
                                 16'($urandom));
                end
            end
            else
                send_command(2'($urandom), 3'($urandom), 3'($urandom), 16'($urandom));
        end
        cmd_bus.valid <= 1'b0;

        while (sb.expected_entries.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: sim.f
sv/apsp_pkg.sv
sv/apsp_cmd_if.sv
sv/apsp_entry_if.sv
sv/apsp_mem.sv
sv/apsp_relax.sv
sv/all_pairs_shortest_path.sv
bench/all_pairs_shortest_path_tb.sv
